FILE: hdl/rwmf_pkg.sv
package rwmf_pkg;

    localparam int MAX_RADIUS = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int LINE_SLOTS = 2 * MAX_RADIUS;
    localparam int WIN_TAPS   = 2 * MAX_RADIUS + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(HEIGHT_LIMIT);
    localparam int SLOT_W     = $clog2(LINE_SLOTS);
    localparam int RAD_W      = 2;
    localparam int DIM_W      = 11;
    localparam int K_W        = $clog2(2 * MAX_RADIUS + 2);
    localparam int PIX_W      = 24;
    localparam int RAM_DEPTH  = LINE_SLOTS * MAX_WIDTH;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture pixel, start column maximum
        logic rd;       // issue line read for tap k
        logic acc;      // merge returned line data
        logic fin;      // write line, shift window, advance counters
        logic emit;     // load output register
    } rwmf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [K_W-1:0] taps;   // lines above to read
        logic           hit;    // this pixel completes a window
    } rwmf_sts_t;

    function automatic logic [PIX_W-1:0] chan_max(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] res;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            res[i*8 +: 8] = (a[i*8 +: 8] > b[i*8 +: 8]) ? a[i*8 +: 8] : b[i*8 +: 8];
        end
        return res;
    endfunction

endpackage

FILE: hdl/rwmf_ram.sv
module rwmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/rwmf_ctrl.sv
module rwmf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rwmf_pkg::rwmf_sts_t sts,
    output rwmf_pkg::rwmf_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [rwmf_pkg::K_W-1:0] k_reg, k_next;   // reads issued
    logic rd_pend_reg, rd_pend_next;

    // output slot is free or being drained this cycle
    logic out_free;
    assign out_free = !out_valid || out_ready;

    assign in_ready = (state_reg == S_IDLE);

    // sequencing of line reads, one per cycle, each merged in the cycle after its read
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        rd_pend_next = 1'b0;
        cmd          = '0;
        cmd.acc      = rd_pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (k_reg < sts.taps)
                begin
                    cmd.rd       = 1'b1;
                    rd_pend_next = 1'b1;
                    k_next       = k_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!sts.hit || out_free)
                begin
                    cmd.fin    = 1'b1;
                    cmd.emit   = sts.hit;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

endmodule

FILE: hdl/rwmf_dp.sv
module rwmf_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rwmf_pkg::PIX_W-1:0]   pixel_rgb,
    input  logic                         cfg_valid,
    input  logic [1:0]                   cfg_index,
    input  logic [rwmf_pkg::DIM_W-1:0]   cfg_data,
    input  rwmf_pkg::rwmf_cmd_t          cmd,
    output rwmf_pkg::rwmf_sts_t          sts,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [31:0]                  max_pixel,
    output logic [9:0]                   center_col,
    output logic [9:0]                   center_row
);

    localparam int COL_W  = rwmf_pkg::COL_W;
    localparam int ROW_W  = rwmf_pkg::ROW_W;
    localparam int SLOT_W = rwmf_pkg::SLOT_W;
    localparam int SUM_W  = rwmf_pkg::SLOT_W + 1;
    localparam int K_W    = rwmf_pkg::K_W;
    localparam int PIX_W  = rwmf_pkg::PIX_W;
    localparam int DIM_W  = rwmf_pkg::DIM_W;
    localparam int TAPS   = rwmf_pkg::WIN_TAPS;

    // configuration registers
    logic [rwmf_pkg::RAD_W-1:0] rad_reg;
    logic [DIM_W-1:0]           wid_reg, hgt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg <= 2'd1;
            wid_reg <= 11'd640;
            hgt_reg <= 11'd480;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rwmf_pkg::REG_RADIUS: rad_reg <= cfg_data[1:0];
                rwmf_pkg::REG_WIDTH:  wid_reg <= cfg_data;
                rwmf_pkg::REG_HEIGHT: hgt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective radius, width and height
    logic [rwmf_pkg::RAD_W-1:0] r_eff;
    logic [DIM_W-1:0]           w_eff, h_eff;
    logic [K_W-1:0]             span;
    assign r_eff = (rad_reg > rwmf_pkg::RAD_W'(rwmf_pkg::MAX_RADIUS))
                   ? rwmf_pkg::RAD_W'(rwmf_pkg::MAX_RADIUS) : rad_reg;
    assign w_eff = (wid_reg == '0) ? DIM_W'(1)
                 : (wid_reg > DIM_W'(rwmf_pkg::MAX_WIDTH)) ? DIM_W'(rwmf_pkg::MAX_WIDTH)
                 : wid_reg;
    assign h_eff = (hgt_reg == '0) ? DIM_W'(1)
                 : (hgt_reg > DIM_W'(rwmf_pkg::HEIGHT_LIMIT))
                 ? DIM_W'(rwmf_pkg::HEIGHT_LIMIT) : hgt_reg;
    assign span = K_W'({r_eff, 1'b0});

    // position counters, normalized on load; slot follows row modulo line count
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
    logic [SLOT_W-1:0] pos_slot;
    logic [SLOT_W-1:0] slot_inc;
    logic [ROW_W:0]    row_inc;

    assign slot_inc = (slot_reg == SLOT_W'(rwmf_pkg::LINE_SLOTS - 1)) ? '0
                    : slot_reg + 1'b1;

    always_comb
    begin
        pos_col  = col_reg;
        pos_row  = row_reg;
        pos_slot = slot_reg;
        row_inc  = {1'b0, row_reg} + 1'b1;
        if ({1'b0, col_reg} >= w_eff)
        begin
            pos_col = '0;
            if ({1'b0, row_inc} >= {1'b0, h_eff})
            begin
                pos_row  = '0;
                pos_slot = '0;
            end
            else
            begin
                pos_row  = row_inc[ROW_W-1:0];
                pos_slot = slot_inc;
            end
        end
        if ({1'b0, pos_row} >= h_eff)
        begin
            pos_row  = '0;
            pos_slot = '0;
        end
    end

    // pixel and column maximum
    logic [PIX_W-1:0] pix_reg, vmax_reg;
    logic [K_W-1:0]   rk_reg;
    logic [PIX_W-1:0] rdata;
    logic [SLOT_W-1:0] rd_slot, wr_slot;
    logic [SUM_W-1:0]  rd_sum;

    assign sts.taps = ({1'b0, cur_row_reg} < {{(ROW_W+1-K_W){1'b0}}, span})
                      ? K_W'(cur_row_reg) : span;
    assign sts.hit  = ({1'b0, cur_col_reg} >= {{(COL_W+1-K_W){1'b0}}, span}) &&
                      ({1'b0, cur_row_reg} >= {{(ROW_W+1-K_W){1'b0}}, span});

    // slot of the line rk+1 rows above, wrapped over the line count
    assign rd_sum  = {1'b0, cur_slot_reg} + SUM_W'(rwmf_pkg::LINE_SLOTS - 1)
                   - SUM_W'(rk_reg);
    assign rd_slot = (rd_sum >= SUM_W'(rwmf_pkg::LINE_SLOTS))
                   ? SLOT_W'(rd_sum - SUM_W'(rwmf_pkg::LINE_SLOTS))
                   : rd_sum[SLOT_W-1:0];
    assign wr_slot = cur_slot_reg;

    rwmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (rwmf_pkg::RAM_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (cmd.fin),
        .waddr ({wr_slot, cur_col_reg}),
        .wdata (pix_reg),
        .raddr ({rd_slot, cur_col_reg}),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg      <= pixel_rgb;
            vmax_reg     <= pixel_rgb;
            cur_col_reg  <= pos_col;
            cur_row_reg  <= pos_row;
            cur_slot_reg <= pos_slot;
        end
        else if (cmd.acc)
        begin
            vmax_reg <= rwmf_pkg::chan_max(vmax_reg, rdata);
        end
    end

    // tap index of next read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk_reg <= '0;
        end
        else if (cmd.load)
        begin
            rk_reg <= '0;
        end
        else if (cmd.rd)
        begin
            rk_reg <= rk_reg + 1'b1;
        end
    end

    // column maxima window and horizontal maximum
    logic [PIX_W-1:0] win_reg [TAPS];
    logic [PIX_W-1:0] hmax;

    always_comb
    begin
        hmax = vmax_reg;
        for (int i = 0; i < TAPS - 1; i++)
        begin
            if (K_W'(i + 1) <= span)
            begin
                hmax = rwmf_pkg::chan_max(hmax, win_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.fin)
        begin
            win_reg[0] <= vmax_reg;
            for (int i = 1; i < TAPS; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // counter advance
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    crow_inc;
    logic [SLOT_W-1:0] cur_slot_inc;
    assign col_inc  = {1'b0, cur_col_reg} + 1'b1;
    assign crow_inc = {1'b0, cur_row_reg} + 1'b1;
    assign cur_slot_inc = (cur_slot_reg == SLOT_W'(rwmf_pkg::LINE_SLOTS - 1)) ? '0
                        : cur_slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cmd.fin)
        begin
            if ({1'b0, col_inc} >= {1'b0, w_eff})
            begin
                col_reg <= '0;
                if ({1'b0, crow_inc} >= {1'b0, h_eff})
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= crow_inc[ROW_W-1:0];
                    slot_reg <= cur_slot_inc;
                end
            end
            else
            begin
                col_reg  <= col_inc[COL_W-1:0];
                row_reg  <= cur_row_reg;
                slot_reg <= cur_slot_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            max_pixel  <= {rwmf_pkg::ALPHA_OPAQUE, hmax};
            center_col <= 10'(cur_col_reg - COL_W'(r_eff));
            center_row <= 10'(cur_row_reg - ROW_W'(r_eff));
        end
    end

endmodule

FILE: hdl/rgb_window_max_filter_top.sv
// Square-window maximum filter for a raster RGB stream. A pixel on the first
// line or with r = 0 passes through load, one empty read step and write-back;
// any other pixel passes through load, one line-buffer read for each of the
// min(row, 2r) lines above through the single read port of the line RAM, a
// step for the last read data to merge, a step to leave the read phase, and
// write-back. A result lies in an output register and the next pixel is taken
// while it waits; a pixel that completes a window holds in its write-back cycle
// until that register is free. Border pixels give no beat; max_pixel carries
// alpha 0xFF. Config registers: 0 radius, 1 width, 2 height; write while idle.
module rgb_window_max_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] pixel_rgb,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] max_pixel,
    output logic [9:0]  center_col,
    output logic [9:0]  center_row,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    rwmf_pkg::rwmf_cmd_t cmd;
    rwmf_pkg::rwmf_sts_t sts;

    assign cfg_ready = 1'b1;

    rwmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rwmf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_rgb  (pixel_rgb),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .max_pixel  (max_pixel),
        .center_col (center_col),
        .center_row (center_row)
    );

endmodule

FILE: hdl/rwmf_checker.sv
module rwmf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] max_pixel
);

    // results always carry opaque alpha
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> max_pixel[31:24] == 8'hFF)
        else $error("alpha not opaque");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(max_pixel))
        else $error("result dropped");

    // an accepted pixel blocks input for at least the following cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken back to back");

    // no result appears without a pixel in flight the cycle before
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without pixel");

endmodule

bind rgb_window_max_filter_top rwmf_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .max_pixel (max_pixel)
);
